// ----- rtl/ptaq_pkg.sv -----
`default_nettype none
package ptaq_pkg;

  localparam int NUM_TASKS_DEF  = 64;
  localparam int NUM_LEVELS_DEF = 4;
  localparam int CMDQ_DEPTH     = 2;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_FINISH = 2'd1,
    OP_CANCEL = 2'd2,
    OP_RSVD   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    EV_ADDED      = 3'd0,
    EV_TO_RUN     = 3'd1,
    EV_OUT_READY  = 3'd2,
    EV_OUT_RUN    = 3'd3,
    EV_CANCEL_REQ = 3'd4,
    EV_REJECT     = 3'd5
  } ev_e;

  typedef enum logic [1:0] {
    LOC_FREE  = 2'd0,
    LOC_READY = 2'd1,
    LOC_RUN   = 2'd2
  } loc_e;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_FINISH,
    CMD_CANCEL,
    CMD_REJECT
  } cmd_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_LINK,
    S_EMIT,
    S_BAL0,
    S_BAL1
  } state_e;

  typedef logic [6:0] cfg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] task_id;
    logic [1:0] task_priority;
  } item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [5:0] event_task;
    logic [6:0] ready_count;
    logic [6:0] run_count;
    logic       last;
  } result_t;

  typedef struct packed {
    cmd_e       kind;
    logic [5:0] task_id;
    logic [1:0] task_priority;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/ptaq_stream_if.sv -----
`default_nettype none
interface ptaq_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/priority_task_admission_queue.sv -----
// Path: an accepted request is registered in the front end, queued in the command FIFO,
// then run by the back end through decide, link (add only) and emit; a task admitted
// to run gives a second result through BAL0, BAL1 and emit. The table sequencer in the
// back end does one linked-list memory access pass per step and takes a new request
// only when idle, after emitting its results. Reset: counts and slot limit clear at
// once; the location table is then swept, during which no request is accepted.
`default_nettype none
module priority_task_admission_queue import ptaq_pkg::*; #(
  parameter int NUM_TASKS  = NUM_TASKS_DEF,
  parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  ptaq_stream_if.sink   cfg_i,
  ptaq_stream_if.sink   item_i,
  ptaq_stream_if.source result_o
);

  cmd_t front_cmd, q_cmd;
  logic front_valid, front_ready, q_valid, q_pop, busy;

  ptaq_front #(
    .NUM_TASKS  (NUM_TASKS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .busy_i      (busy),
    .item_i      (item_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  ptaq_cmd_fifo u_cmdq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_cmd),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (q_cmd),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop)
  );

  ptaq_back #(
    .NUM_TASKS  (NUM_TASKS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .cmd_i       (q_cmd),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (q_pop),
    .clearing_o  (busy),
    .result_o    (result_o)
  );

endmodule
`default_nettype wire

// ----- rtl/ptaq_front.sv -----
`default_nettype none
module ptaq_front import ptaq_pkg::*; #(
  parameter int NUM_TASKS  = NUM_TASKS_DEF,
  parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     busy_i,
  ptaq_stream_if.sink   item_i,
  output cmd_t          cmd_o,
  output logic          cmd_valid_o,
  input  wire logic     cmd_ready_i
);

  logic v_q, v_d;
  cmd_t c_q, c_d;
  cmd_t cls;
  logic id_ok, pri_ok;

  assign id_ok  = 32'(item_i.data.task_id) < NUM_TASKS;
  assign pri_ok = 32'(item_i.data.task_priority) < NUM_LEVELS;

  // classify the request; anything malformed goes straight to reject
  always_comb begin
    cls.task_id       = item_i.data.task_id;
    cls.task_priority = item_i.data.task_priority;
    cls.kind          = CMD_REJECT;
    if (id_ok) begin
      unique case (op_e'(item_i.data.operation))
        OP_ADD:    cls.kind = pri_ok ? CMD_ADD : CMD_REJECT;
        OP_FINISH: cls.kind = CMD_FINISH;
        OP_CANCEL: cls.kind = CMD_CANCEL;
        default:   cls.kind = CMD_REJECT;
      endcase
    end
  end

  assign item_i.ready = !busy_i && (!v_q || cmd_ready_i);
  assign cmd_o        = c_q;
  assign cmd_valid_o  = v_q;

  always_comb begin
    v_d = v_q && !cmd_ready_i;
    c_d = c_q;
    if (item_i.valid && item_i.ready) begin
      v_d = 1'b1;
      c_d = cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
  end

endmodule
`default_nettype wire

// ----- rtl/ptaq_cmd_fifo.sv -----
`default_nettype none
module ptaq_cmd_fifo import ptaq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cmd_t      push_data_i,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  output cmd_t      pop_data_o,
  output logic      pop_valid_o,
  input  wire logic pop_i
);

  localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          mem_q [CMDQ_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          push, pop;

  assign push_ready_o = cnt_q != CW'(CMDQ_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ptaq_back.sv -----
`default_nettype none
module ptaq_back import ptaq_pkg::*; #(
  parameter int NUM_TASKS  = NUM_TASKS_DEF,
  parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  ptaq_stream_if.sink   cfg_i,
  input  cmd_t          cmd_i,
  input  wire logic     cmd_valid_i,
  output logic          cmd_pop_o,
  output logic          clearing_o,
  ptaq_stream_if.source result_o
);

  localparam int TID_W = $clog2(NUM_TASKS);
  localparam int LVL_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int CNT_W = $clog2(NUM_TASKS + 1);

  state_e             state_q, state_d;
  logic [TID_W-1:0]   clr_q, clr_d;
  cmd_t               cmd_q, cmd_d;
  ev_e                ev_q, ev_d;
  logic [5:0]         evt_q, evt_d;
  logic               bal_q, bal_d;
  logic [LVL_W-1:0]   blv_q, blv_d;
  logic [TID_W-1:0]   bt_q, bt_d;
  cfg_t               max_q;
  logic [CNT_W-1:0]   ready_q, ready_d, run_q, run_d;
  logic [TID_W-1:0]   head_q [NUM_LEVELS];
  logic [TID_W-1:0]   head_d [NUM_LEVELS];
  logic [TID_W-1:0]   tail_q [NUM_LEVELS];
  logic [TID_W-1:0]   tail_d [NUM_LEVELS];
  logic [CNT_W-1:0]   cnt_q [NUM_LEVELS];
  logic [CNT_W-1:0]   cnt_d [NUM_LEVELS];
  logic               out_v_q, out_v_d;
  result_t            out_q, out_d;

  loc_e               loc_mem [NUM_TASKS];
  logic [LVL_W-1:0]   lvl_mem [NUM_TASKS];
  logic [TID_W-1:0]   nxt_mem [NUM_TASKS];
  logic [TID_W-1:0]   prv_mem [NUM_TASKS];
  loc_e               loc_rd_q;
  logic [LVL_W-1:0]   lvl_rd_q;
  logic [TID_W-1:0]   nxt_rd_q, prv_rd_q;

  logic [TID_W-1:0]   rd_addr, tid;
  logic               loc_we, lvl_we, nxt_we, prv_we;
  logic [TID_W-1:0]   loc_wa, nxt_wa, nxt_wd, prv_wa, prv_wd;
  loc_e               loc_wd;
  logic [LVL_W-1:0]   lv_sel, enc;
  logic               bal_ok, do_unlink, is_head, is_tail;
  logic [TID_W-1:0]   ut;

  assign tid        = TID_W'(cmd_q.task_id);
  assign clearing_o = state_q == S_CLEAR;
  assign cfg_i.ready = 1'b1;
  assign result_o.valid = out_v_q;
  assign result_o.data  = out_q;

  assign bal_ok = (ready_q != '0) && ((max_q == '0) || (32'(run_q) < 32'(max_q)));

  // highest nonempty level wins
  always_comb begin
    enc = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (cnt_q[l] != '0) begin
        enc = LVL_W'(l);
      end
    end
  end

  always_comb begin
    unique case (state_q)
      S_DECIDE: lv_sel = (cmd_q.kind == CMD_ADD) ? LVL_W'(cmd_q.task_priority) : lvl_rd_q;
      S_BAL0:   lv_sel = enc;
      default:  lv_sel = blv_q;
    endcase
  end

  assign ut      = (state_q == S_BAL1) ? bt_q : tid;
  assign is_head = head_q[lv_sel] == ut;
  assign is_tail = tail_q[lv_sel] == ut;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cmd_d     = cmd_q;
    ev_d      = ev_q;
    evt_d     = evt_q;
    bal_d     = bal_q;
    blv_d     = blv_q;
    bt_d      = bt_q;
    ready_d   = ready_q;
    run_d     = run_q;
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    out_v_d   = out_v_q && !result_o.ready;
    out_d     = out_q;
    cmd_pop_o = 1'b0;
    rd_addr   = tid;
    loc_we    = 1'b0;
    loc_wa    = tid;
    loc_wd    = LOC_FREE;
    lvl_we    = 1'b0;
    nxt_we    = 1'b0;
    nxt_wa    = tid;
    nxt_wd    = tid;
    prv_we    = 1'b0;
    prv_wa    = tid;
    prv_wd    = tid;
    do_unlink = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        loc_we = 1'b1;
        loc_wa = clr_q;
        clr_d  = clr_q + 1'b1;
        if (clr_q == TID_W'(NUM_TASKS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        rd_addr = TID_W'(cmd_i.task_id);
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          state_d   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        evt_d   = cmd_q.task_id;
        bal_d   = 1'b0;
        ev_d    = EV_REJECT;
        state_d = S_EMIT;
        unique case (cmd_q.kind)
          CMD_ADD: begin
            if (loc_rd_q == LOC_FREE) begin
              ev_d           = EV_ADDED;
              bal_d          = 1'b1;
              loc_we         = 1'b1;
              loc_wd         = LOC_READY;
              lvl_we         = 1'b1;
              tail_d[lv_sel] = tid;
              cnt_d[lv_sel]  = cnt_q[lv_sel] + 1'b1;
              ready_d        = ready_q + 1'b1;
              prv_we         = 1'b1;
              if (cnt_q[lv_sel] == '0) begin
                head_d[lv_sel] = tid;
              end else begin
                prv_wd = tail_q[lv_sel];
                nxt_we = 1'b1;
                nxt_wa = tail_q[lv_sel];
              end
              state_d = S_LINK;
            end
          end
          CMD_FINISH: begin
            if (loc_rd_q == LOC_RUN) begin
              ev_d   = EV_OUT_RUN;
              bal_d  = 1'b1;
              loc_we = 1'b1;
              if (run_q != '0) begin
                run_d = run_q - 1'b1;
              end
            end
          end
          CMD_CANCEL: begin
            if (loc_rd_q == LOC_READY) begin
              ev_d      = EV_OUT_READY;
              loc_we    = 1'b1;
              do_unlink = 1'b1;
            end else if (loc_rd_q == LOC_RUN) begin
              ev_d = EV_CANCEL_REQ;
            end
          end
          default: ;
        endcase
      end
      S_LINK: begin
        // new tail points at itself
        nxt_we  = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_v_q || result_o.ready) begin
          out_v_d           = 1'b1;
          out_d.event_res   = ev_q;
          out_d.event_task  = evt_q;
          out_d.ready_count = 7'(ready_q);
          out_d.run_count   = 7'(run_q);
          out_d.last        = !(bal_q && bal_ok);
          state_d           = (bal_q && bal_ok) ? S_BAL0 : S_IDLE;
        end
      end
      S_BAL0: begin
        blv_d   = lv_sel;
        bt_d    = head_q[lv_sel];
        rd_addr = head_q[lv_sel];
        state_d = S_BAL1;
      end
      S_BAL1: begin
        do_unlink = 1'b1;
        loc_we    = 1'b1;
        loc_wa    = bt_q;
        loc_wd    = LOC_RUN;
        run_d     = run_q + 1'b1;
        ev_d      = EV_TO_RUN;
        evt_d     = 6'(bt_q);
        bal_d     = 1'b0;
        state_d   = S_EMIT;
      end
      default: state_d = S_IDLE;
    endcase

    // unlink ut from level lv_sel using its registered links
    if (do_unlink) begin
      ready_d = ready_q - 1'b1;
      if (is_head) begin
        head_d[lv_sel] = nxt_rd_q;
      end else begin
        nxt_we = 1'b1;
        nxt_wa = prv_rd_q;
        nxt_wd = is_tail ? prv_rd_q : nxt_rd_q;
      end
      if (is_tail) begin
        tail_d[lv_sel] = prv_rd_q;
      end else begin
        prv_we = 1'b1;
        prv_wa = nxt_rd_q;
        prv_wd = is_head ? nxt_rd_q : prv_rd_q;
      end
      if (cnt_q[lv_sel] != '0) begin
        cnt_d[lv_sel] = cnt_q[lv_sel] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      max_q   <= '0;
      ready_q <= '0;
      run_q   <= '0;
      out_v_q <= 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        cnt_q[l] <= '0;
      end
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ready_q <= ready_d;
      run_q   <= run_d;
      out_v_q <= out_v_d;
      cnt_q   <= cnt_d;
      if (cfg_i.valid) begin
        max_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    ev_q   <= ev_d;
    evt_q  <= evt_d;
    bal_q  <= bal_d;
    blv_q  <= blv_d;
    bt_q   <= bt_d;
    head_q <= head_d;
    tail_q <= tail_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (loc_we) begin
      loc_mem[loc_wa] <= loc_wd;
    end
    if (lvl_we) begin
      lvl_mem[tid] <= lv_sel;
    end
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    loc_rd_q <= loc_mem[rd_addr];
    lvl_rd_q <= lvl_mem[rd_addr];
    nxt_rd_q <= nxt_mem[rd_addr];
    prv_rd_q <= prv_mem[rd_addr];
  end

  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(ready_q) + 32'(run_q)) <= NUM_TASKS)
    else $error("ready plus running exceeds task count");

  a_bal_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BAL1 |-> $past(state_q) == S_BAL0)
    else $error("admission step entered out of order");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_q.last) |->
      (out_q.event_res == EV_ADDED || out_q.event_res == EV_OUT_RUN))
    else $error("non-final result on an event that has no follow-up");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !cmd_pop_o)
    else $error("command taken during clearing sweep");

endmodule
`default_nettype wire
